// File: hdl/spike_latency_jitter_monitor_defines.svh
// Assertion helpers for the checker file.
`ifndef SPIKE_LATENCY_JITTER_MONITOR_DEFINES_SVH
`define SPIKE_LATENCY_JITTER_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SLMON_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spike monitor check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SLMON_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spike monitor check failed");

`endif

// File: hdl/slmon_pkg.sv
package slmon_pkg;

    localparam int TIME_BITS     = 40;
    localparam int SUM_BITS      = 48;
    localparam int HOPS_SUM_BITS = 40;
    localparam int HOPS_BITS     = 8;
    localparam int HMIN_BITS     = 14;
    localparam int STAT_BITS     = 32;
    localparam int CNT_BITS      = 32;
    localparam int PER_BITS      = 16;
    localparam int DIFF_BITS     = TIME_BITS + 2;

    localparam int DIV_STEPS     = STAT_BITS / 2;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam int S_RAW_W  = 2 * TIME_BITS + HOPS_BITS;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W  = 3 * CNT_BITS + 4 * STAT_BITS + 2 * SUM_BITS
                              + HOPS_BITS + HMIN_BITS + HOPS_SUM_BITS;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [PER_BITS-1:0]  RESET_PERIOD   = PER_BITS'(1000);
    localparam logic [STAT_BITS-1:0] RESET_MIN_STAT = STAT_BITS'(100);
    localparam logic [HMIN_BITS-1:0] RESET_MIN_HOPS = HMIN_BITS'(10000);

    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_RECEIVE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELAY,
        ST_DELAY_WAIT,
        ST_ISI,
        ST_ISI_WAIT,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [STAT_BITS-1:0] dividend;
        logic [PER_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [STAT_BITS-1:0] quotient;
    } t_div_rsp;

    // Clamp an exact difference to the signed 32-bit range.
    function automatic logic [STAT_BITS-1:0] f_sat32(input logic signed [DIFF_BITS-1:0] v);
        logic signed [DIFF_BITS-1:0] hi;
        logic signed [DIFF_BITS-1:0] lo;
        hi = DIFF_BITS'(2147483647);
        lo = -DIFF_BITS'(2147483647) - DIFF_BITS'(1);
        if (v > hi) begin
            return {1'b0, {(STAT_BITS-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(STAT_BITS-1){1'b0}}};
        end
        return v[STAT_BITS-1:0];
    endfunction

    // Unsigned magnitude of a two's complement value; the most negative maps to 2^31.
    function automatic logic [STAT_BITS-1:0] f_mag(input logic [STAT_BITS-1:0] v);
        return v[STAT_BITS-1] ? (~v + STAT_BITS'(1)) : v;
    endfunction

endpackage

// File: hdl/spike_latency_jitter_monitor.sv
// Spike latency and jitter monitor.
// Input stream (s_axis): one request per spike event. tuser carries the mode
// (0 = generated here, 1 = received); tdata carries spike time, receive time
// and the intra-segment hop count, both times in picoseconds.
// Output stream (m_axis): one result per request holding every statistic after
// the update: counters, max/min/sum of delay, ISI distortion and hops.
// Config: i_cfg_we writes the clock period in ps (0 acts as 1) at any edge;
// write it only while the block is idle.
// Flow: a generate request goes straight to its update step; a receive
// request first makes two passes through one shared divider retiring two
// quotient bits per cycle (each division: a load, 16 two-bit steps, then
// a done flag with the quotient), one for the delay and one for the ISI.
// s_axis_tready is high only in the idle state, so requests are taken one at
// a time: no new request is taken until the last one has passed its update
// step. The next request may be accepted while a result still waits.
// If m_axis_tready stays low, the result is held and the following request
// stops in its update step until the pending result is taken.
// Reset (synchronous, active low) clears all statistics to their start values
// (min delay and min ISI 100, min hops 10000, others 0) and the period to 1000.
module spike_latency_jitter_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [slmon_pkg::PER_BITS-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [39:0] spike_time, [79:40] receive_time, [87:80] intra_hops
    input  logic [slmon_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] mode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] sent_count, [63:32] received_count, [95:64] disorder_count,
    // [127:96] delay_peak, [159:128] delay_floor, [207:160] delay_total,
    // [239:208] max_isi, [271:240] min_isi, [319:272] sum_isi,
    // [327:320] max_hops, [341:328] min_hops, [381:342] sum_hops, [383:382] zero
    output logic [slmon_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import slmon_pkg::*;

    t_state r_state, n_state;
    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [PER_BITS-1:0]  r_period;

    // captured request
    logic                 r_mode;
    logic [TIME_BITS-1:0] r_st, r_rt;
    logic [HOPS_BITS-1:0] r_hops;
    logic                 r_neg;
    logic [STAT_BITS-1:0] r_delay, r_isi;

    // running state
    logic [TIME_BITS-1:0]     r_last_rcv, r_last_spk;
    logic [CNT_BITS-1:0]      r_sent, r_rcvd, r_disorder;
    logic signed [STAT_BITS-1:0] r_dmax, r_dmin;
    logic [SUM_BITS-1:0]      r_dsum;
    logic [STAT_BITS-1:0]     r_imax, r_imin;
    logic [SUM_BITS-1:0]      r_isum;
    logic [HOPS_BITS-1:0]     r_hmax;
    logic [HMIN_BITS-1:0]     r_hmin;
    logic [HOPS_SUM_BITS-1:0] r_hsum;
    logic                     r_out_valid;

    logic                 w_accept, w_update, w_start, w_neg;
    logic [STAT_BITS-1:0] w_sat, w_mag, w_quo_signed;
    logic signed [DIFF_BITS-1:0] w_ddiff, w_idiff;
    logic [TIME_BITS:0]   w_asum, w_bsum;
    logic [STAT_BITS-1:0] w_mag_isi, w_mag_imax, w_mag_imin;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // delay = rt - st; ISI = (rt + last_spike) - (last_receive + st), both exact
    always_comb begin
        w_ddiff = signed'({2'b00, r_rt}) - signed'({2'b00, r_st});
        w_asum  = {1'b0, r_rt} + {1'b0, r_last_spk};
        w_bsum  = {1'b0, r_last_rcv} + {1'b0, r_st};
        w_idiff = signed'({1'b0, w_asum}) - signed'({1'b0, w_bsum});
        // no ISI until a first spike has arrived
        w_sat   = (r_state == ST_DELAY) ? f_sat32(w_ddiff) :
                  ((r_rcvd == '0) ? '0 : f_sat32(w_idiff));
        w_neg   = w_sat[STAT_BITS-1];
        w_mag   = f_mag(w_sat);
        w_quo_signed = r_neg ? (~w_rsp.quotient + STAT_BITS'(1)) : w_rsp.quotient;
    end

    assign w_req.start    = w_start;
    assign w_req.dividend = w_mag;
    assign w_req.divisor  = (r_period == '0) ? PER_BITS'(1) : r_period;

    slmon_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_start       = 1'b0;
        w_update      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == MODE_RECEIVE) ? ST_DELAY : ST_UPDATE;
                end
            end
            ST_DELAY: begin
                w_start = 1'b1;
                n_state = ST_DELAY_WAIT;
            end
            ST_DELAY_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ST_ISI;
                end
            end
            ST_ISI: begin
                w_start = 1'b1;
                n_state = ST_ISI_WAIT;
            end
            ST_ISI_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // hold until the previous result has been taken
                if (!r_out_valid || m_axis_tready) begin
                    w_update = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // capture request and signed quotients
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= s_axis_tuser;
            r_st   <= s_axis_tdata[TIME_BITS-1:0];
            r_rt   <= s_axis_tdata[2*TIME_BITS-1:TIME_BITS];
            r_hops <= s_axis_tdata[2*TIME_BITS+HOPS_BITS-1:2*TIME_BITS];
        end
        if (w_start) begin
            r_neg <= w_neg;
        end
        if (r_state == ST_DELAY_WAIT && w_rsp.done) begin
            r_delay <= w_quo_signed;
        end
        if (r_state == ST_ISI_WAIT && w_rsp.done) begin
            r_isi <= w_quo_signed;
        end
    end

    always_comb begin
        w_mag_isi  = f_mag(r_isi);
        w_mag_imax = f_mag(r_imax);
        w_mag_imin = f_mag(r_imin);
    end

    // statistics update and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rcv  <= '0;
            r_last_spk  <= '0;
            r_sent      <= '0;
            r_rcvd      <= '0;
            r_disorder  <= '0;
            r_dmax      <= '0;
            r_dmin      <= RESET_MIN_STAT;
            r_dsum      <= '0;
            r_imax      <= '0;
            r_imin      <= RESET_MIN_STAT;
            r_isum      <= '0;
            r_hmax      <= '0;
            r_hmin      <= RESET_MIN_HOPS;
            r_hsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_update) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_update) begin
                if (r_mode == MODE_GENERATE) begin
                    r_sent <= (&r_sent) ? r_sent : r_sent + CNT_BITS'(1);
                end else begin
                    if (r_st < r_last_spk && !(&r_disorder)) begin
                        r_disorder <= r_disorder + CNT_BITS'(1);
                    end
                    r_last_rcv <= r_rt;
                    r_last_spk <= r_st;
                    r_rcvd     <= (&r_rcvd) ? r_rcvd : r_rcvd + CNT_BITS'(1);

                    if (signed'(r_delay) > r_dmax) begin
                        r_dmax <= r_delay;
                    end
                    if (signed'(r_delay) < r_dmin) begin
                        r_dmin <= r_delay;
                    end
                    r_dsum <= r_dsum + {{(SUM_BITS-STAT_BITS){r_delay[STAT_BITS-1]}}, r_delay};

                    // ISI extremes by magnitude; ties keep the older value
                    if (w_mag_isi > w_mag_imax) begin
                        r_imax <= r_isi;
                    end
                    if (w_mag_isi < w_mag_imin) begin
                        r_imin <= r_isi;
                    end
                    r_isum <= r_isum + {{(SUM_BITS-STAT_BITS){r_isi[STAT_BITS-1]}}, r_isi};

                    if (r_hops > r_hmax) begin
                        r_hmax <= r_hops;
                    end
                    if ({{(HMIN_BITS-HOPS_BITS){1'b0}}, r_hops} < r_hmin) begin
                        r_hmin <= {{(HMIN_BITS-HOPS_BITS){1'b0}}, r_hops};
                    end
                    r_hsum <= r_hsum + {{(HOPS_SUM_BITS-HOPS_BITS){1'b0}}, r_hops};
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-M_RAW_W){1'b0}},
                            r_hsum, r_hmin, r_hmax,
                            r_isum, r_imin, r_imax,
                            r_dsum, r_dmin, r_dmax,
                            r_disorder, r_rcvd, r_sent};

endmodule

// File: hdl/slmon_div.sv
module slmon_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slmon_pkg::t_div_req i_req,
    output slmon_pkg::t_div_rsp o_rsp
);
    import slmon_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [STAT_BITS-1:0]    r_quo;
    logic [PER_BITS-1:0]     r_rem;
    logic [PER_BITS-1:0]     r_dvs;

    logic [PER_BITS:0] w_sh1, w_sh2, w_r1, w_r2;
    logic              w_ge1, w_ge2;

    // Two restoring steps per cycle.
    always_comb begin
        w_sh1 = {r_rem, r_quo[STAT_BITS-1]};
        w_ge1 = w_sh1 >= {1'b0, r_dvs};
        w_r1  = w_ge1 ? (w_sh1 - {1'b0, r_dvs}) : w_sh1;
        w_sh2 = {w_r1[PER_BITS-1:0], r_quo[STAT_BITS-2]};
        w_ge2 = w_sh2 >= {1'b0, r_dvs};
        w_r2  = w_ge2 ? (w_sh2 - {1'b0, r_dvs}) : w_sh2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[STAT_BITS-3:0], w_ge1, w_ge2};
            r_rem <= w_r2[PER_BITS-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: hdl/slmon_checker.sv
`include "spike_latency_jitter_monitor_defines.svh"

module slmon_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [slmon_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import slmon_pkg::*;

    // stalled result holds
    `SLMON_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one request in flight: ready drops right after an accept
    `SLMON_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // smallest hop count never exceeds its start value
    `SLMON_ASSERT_IMP(a_min_hops_bound, m_axis_tvalid, m_axis_tdata[341:328] <= RESET_MIN_HOPS)

    // once a spike arrived, max hops is at least min hops
    `SLMON_ASSERT_IMP(a_hops_order, m_axis_tvalid && (m_axis_tdata[63:32] != '0), {6'b000000, m_axis_tdata[327:320]} >= m_axis_tdata[341:328])

endmodule

bind spike_latency_jitter_monitor slmon_checker u_slmon_checker (.*);
